// ----- rtl/acce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES container encryptor package
// Shared types, S-box, xtime round helper, CRC table-entry function.
// ----------------------------------------------------------------------------
package acce_pkg;

    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_IV_HIGH  = 2'd2,
        CFG_IV_LOW   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYEXP,
        ST_ROUND,
        ST_CRC,
        ST_OUT,
        ST_HDR
    } t_state;

    localparam logic [7:0]  HDR_TAG     = 8'hE0;
    localparam logic [7:0]  HDR_VER     = 8'h07;
    localparam logic [31:0] CRC_POLY    = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_MSB     = 32'h80000000;
    localparam int unsigned BLOCK_BITS  = 128;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte-swapped MSB-first remainder of idx<<24
    function automatic logic [31:0] crc_entry(input logic [7:0] idx);
        logic [31:0] v;
        v = {idx, 24'd0};
        for (int i = 0; i < 8; i++) begin
            v = ((v & CRC_MSB) != 32'd0) ? ({v[30:0], 1'b0} ^ CRC_POLY) : {v[30:0], 1'b0};
        end
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/aes_cbc_container_encryptor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128-CBC container encryptor with CRC-32 trailer header
// Flow: a word is accepted in idle, passes the AES rounds, then its CRC step
//   folds the ciphertext in two bytes per cycle; the ciphertext is then held
//   valid until taken, and the next word is accepted only after that.
//   A full last block adds an all-zero pad block, then a header.
// Key write: the round keys are expanded before new words are taken.
//   Reset: synchronous active low; control, key and IV registers zero, round
//   keys expanded from the zero key, CRC set to all ones.
// ----------------------------------------------------------------------------
module aes_cbc_container_encryptor (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // cfg write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    // input: tdata bits 63:0 block_high, 127:64 block_low, 132:128 valid_bytes,
    //        133 restart_chain, 135:134 zero; tlast last_block
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,
    // output: tdata bits 63:0 word_high, 127:64 word_low; tuser item_kind;
    //         tlast final_item
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [127:0] m_axis_tdata,
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);
    import acce_pkg::*;

    t_state        r_state, n_state;
    logic [63:0]   r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic [127:0]  r_chain;
    logic [31:0]   r_crc, n_crc;
    logic [127:0]  r_rk [11];
    logic [127:0]  r_s;
    logic [3:0]    r_cnt;
    logic          r_last, r_pad_pend, r_kexp;
    logic [4:0]    r_pad;
    logic [127:0]  r_out;
    logic          r_kind;
    logic [127:0]  w_round;
    logic [127:0]  w_kprev, w_knext;
    logic [31:0]   w_kt;
    logic [7:0]    w_rcon;
    logic [4:0]    w_v;
    logic [127:0]  w_mask, w_pt;

    acce_round u_round (
        .i_state (r_s),
        .i_rkey  (r_rk[r_cnt]),
        .i_final (r_cnt == 4'd10),
        .o_state (w_round)
    );

    // key expansion step: derive rk[cnt] from rk[cnt-1]
    always_comb begin
        w_kprev = r_rk[r_cnt - 4'd1];
        unique case (r_cnt)
            4'd1: w_rcon = 8'h01;  4'd2: w_rcon = 8'h02;
            4'd3: w_rcon = 8'h04;  4'd4: w_rcon = 8'h08;
            4'd5: w_rcon = 8'h10;  4'd6: w_rcon = 8'h20;
            4'd7: w_rcon = 8'h40;  4'd8: w_rcon = 8'h80;
            4'd9: w_rcon = 8'h1b;  4'd10: w_rcon = 8'h36;
            default: w_rcon = 8'h00;
        endcase
        w_kt = {sbox(w_kprev[23:16]), sbox(w_kprev[15:8]), sbox(w_kprev[7:0]),
                sbox(w_kprev[31:24])} ^ {w_rcon, 24'd0};
        w_knext[127:96] = w_kprev[127:96] ^ w_kt;
        w_knext[95:64]  = w_kprev[95:64] ^ w_knext[127:96];
        w_knext[63:32]  = w_kprev[63:32] ^ w_knext[95:64];
        w_knext[31:0]   = w_kprev[31:0] ^ w_knext[63:32];
    end

    // input masking: keep first v bytes
    always_comb begin
        w_v = (s_axis_tdata[132:128] > 5'd16 || !s_axis_tlast) ? 5'd16
            : s_axis_tdata[132:128];
        for (int i = 0; i < 16; i++) begin
            w_mask[127-8*i -: 8] = (5'(i) < w_v) ? 8'hFF : 8'h00;
        end
        w_pt = {s_axis_tdata[63:0], s_axis_tdata[127:64]} & w_mask;
    end

    // two CRC bytes per cycle, taken from r_s high bytes first
    always_comb begin
        logic [31:0] c;
        c = r_crc;
        for (int k = 0; k < 2; k++) begin
            c = crc_entry(c[7:0] ^ r_s[127-8*k -: 8]) ^ {8'd0, c[31:8]};
        end
        n_crc = c;
    end

    // take words only in idle; hold them off while a key expansion is pending or a register is written
    assign s_axis_tready = (r_state == ST_IDLE) && !r_kexp && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE) && !r_kexp;
    assign m_axis_tvalid = (r_state == ST_OUT) || (r_state == ST_HDR);
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_kind;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (r_kexp) begin
                    n_state = ST_KEYEXP;
                end else if (s_axis_tvalid && s_axis_tready) begin
                    n_state = ST_ROUND;
                end
            end
            ST_KEYEXP: if (r_cnt == 4'd10) n_state = ST_IDLE;
            ST_ROUND:  if (r_cnt == 4'd10) n_state = ST_CRC;
            ST_CRC:    if (r_cnt == 4'd7)  n_state = ST_OUT;
            ST_OUT: begin
                if (m_axis_tready) begin
                    if (r_pad_pend) n_state = ST_ROUND;
                    else if (r_last) n_state = ST_HDR;
                    else n_state = ST_IDLE;
                end
            end
            ST_HDR:    if (m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_key_hi <= '0; r_key_lo <= '0; r_iv_hi <= '0; r_iv_lo <= '0;
            r_chain <= '0;
            r_crc   <= CRC_INIT;
            r_cnt   <= 4'd0;
            r_kexp  <= 1'b1;
            r_last  <= 1'b0;
            r_pad_pend <= 1'b0;
            r_kind  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_KEY_HIGH: begin r_key_hi <= i_cfg_data; r_kexp <= 1'b1; end
                    CFG_KEY_LOW:  begin r_key_lo <= i_cfg_data; r_kexp <= 1'b1; end
                    CFG_IV_HIGH:  r_iv_hi <= i_cfg_data;
                    CFG_IV_LOW:   r_iv_lo <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (r_kexp) begin
                        // load round key 0 and start expansion
                        r_rk[0] <= {r_key_hi, r_key_lo};
                        r_cnt   <= 4'd1;
                        r_kexp  <= 1'b0;
                    end else if (s_axis_tvalid && s_axis_tready) begin
                        r_s <= w_pt ^ r_rk[0] ^
                               (s_axis_tdata[133] ? {r_iv_hi, r_iv_lo} : r_chain);
                        r_cnt <= 4'd1;
                        r_last <= s_axis_tlast;
                        r_pad_pend <= s_axis_tlast && (w_v == 5'd16);
                        r_pad <= 5'd16 - w_v;
                        r_kind <= 1'b0;
                    end
                end
                ST_KEYEXP: begin
                    r_rk[r_cnt] <= w_knext;
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_ROUND: begin
                    r_s <= w_round;
                    if (r_cnt == 4'd10) begin
                        r_chain <= w_round;
                        r_out   <= w_round;
                        r_cnt   <= 4'd0;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_CRC: begin
                    r_crc <= n_crc;
                    r_s   <= {r_s[111:0], 16'd0};
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        if (r_pad_pend) begin
                            // encrypt an all-zero pad block
                            r_pad_pend <= 1'b0;
                            r_pad <= 5'd16;
                            r_s   <= r_chain ^ r_rk[0];
                            r_cnt <= 4'd1;
                        end else if (r_last) begin
                            r_kind <= 1'b1;
                            r_out <= {8'h00, HDR_VER, 8'h01, HDR_TAG, 3'd0, r_pad,
                                      r_crc[31:8], 56'd0, r_crc[7:0]};
                        end
                    end
                end
                ST_HDR: begin
                    if (m_axis_tready) begin
                        r_crc <= CRC_INIT;
                        r_kind <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/acce_round.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES round unit
// One encryption round per call; final round skips MixColumns.
// ----------------------------------------------------------------------------
module acce_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_rkey,
    input  wire logic         i_final,
    output logic      [127:0] o_state
);
    import acce_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = sbox(i_state[127-8*i -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i+4*c] = s[i + 4*((c+i) & 3)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (i_final) begin
                m[4*c]   = t[4*c];
                m[4*c+1] = t[4*c+1];
                m[4*c+2] = t[4*c+2];
                m[4*c+3] = t[4*c+3];
            end else begin
                m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
                m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o_state[127-8*i -: 8] = m[i] ^ i_rkey[127-8*i -: 8];
        end
    end
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// AES-128-CBC container encryptor testbench
// Drives plaintext words and key/IV register writes through their stream
// channels. A built-in model predicts ciphertext, pad blocks and CRC headers,
// and every output word is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acce_pkg::*;

    typedef struct packed {
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        logic [4:0]  nbytes;
        logic        last;
        logic        restart;
    } t_plain;

    typedef struct packed {
        logic        kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        fin;
    } t_cipher;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    aes_cbc_container_encryptor uut (.*);

    always #2 i_clk = ~i_clk;

    // Model state
    logic [7:0]  sb [256];
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic [63:0] chain_hi, chain_lo;
    logic [31:0] crc_acc;
    logic [63:0] rkeys [22];

    t_plain  plain_q [$];
    t_cipher cipher_q [$];
    int      errors = 0;
    int      send_idle = 0;  // percent
    int      recv_stall = 0; // percent
    bit      feeding = 1'b0;

    initial begin
        sb = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    end

    function automatic logic [31:0] sub_word32(input logic [31:0] w);
        return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
    endfunction

    // Rebuild the eleven round keys from the key registers
    task automatic build_round_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
        w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = sub_word32({t[23:0], t[31:24]}) ^ {rc, 24'd0};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) begin
            rkeys[2*r]   = {w[4*r], w[4*r+1]};
            rkeys[2*r+1] = {w[4*r+2], w[4*r+3]};
        end
    endtask

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES-128 block, byte 0 in the top bits of the 128-bit vector
    function automatic logic [127:0] aes128(input logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] k;
        logic [127:0] ct;
        for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8];
        for (int r = 0; r <= 10; r++) begin
            if (r > 0) begin
                for (int i = 0; i < 16; i++) s[i] = sb[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i)%4)];
                for (int c = 0; c < 4; c++) begin
                    if (r < 10) begin
                        s[4*c]   = dbl(t[4*c]) ^ dbl(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                        s[4*c+1] = t[4*c] ^ dbl(t[4*c+1]) ^ dbl(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
                        s[4*c+2] = t[4*c] ^ t[4*c+1] ^ dbl(t[4*c+2]) ^ dbl(t[4*c+3]) ^ t[4*c+3];
                        s[4*c+3] = dbl(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ dbl(t[4*c+3]);
                    end else begin
                        for (int i = 0; i < 4; i++) s[4*c+i] = t[4*c+i];
                    end
                end
            end
            k = {rkeys[2*r], rkeys[2*r+1]};
            for (int i = 0; i < 16; i++) s[i] = s[i] ^ k[127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = s[i];
        return ct;
    endfunction

    // Fold one ciphertext byte into the running checksum
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = {c[7:0] ^ b, 24'd0};
        for (int i = 0; i < 8; i++)
            v = v[31] ? ({v[30:0], 1'b0} ^ 32'h04C11DB7) : {v[30:0], 1'b0};
        return {v[7:0], v[15:8], v[23:16], v[31:24]} ^ (c >> 8);
    endfunction

    task automatic encrypt_block(input logic [127:0] pt);
        logic [127:0] ct;
        ct = aes128(pt ^ {chain_hi, chain_lo});
        {chain_hi, chain_lo} = ct;
        for (int i = 0; i < 16; i++) crc_acc = crc_byte(crc_acc, ct[127-8*i -: 8]);
        cipher_q.push_back('{kind: 1'b0, hi: ct[127:64], lo: ct[63:0], fin: 1'b0});
    endtask

    // Queue the results one plaintext word produces
    task automatic predict_container(input t_plain p);
        int n;
        logic [127:0] msk;
        logic [7:0]   pad;
        n = (p.nbytes > 16) ? 16 : p.nbytes;
        if (!p.last) n = 16;
        if (p.restart) begin
            chain_hi = iv_hi;
            chain_lo = iv_lo;
        end
        msk = (n == 0) ? '0 : ~(128'h0) << (8 * (16 - n));
        encrypt_block({p.blk_hi, p.blk_lo} & msk);
        if (p.last) begin
            if (n == 16) begin
                encrypt_block('0);
                pad = 8'd16;
            end else begin
                pad = 8'(16 - n);
            end
            cipher_q.push_back('{kind: 1'b1,
                hi: {8'h00, HDR_VER, 8'h01, HDR_TAG, pad, crc_acc[31:8]},
                lo: {56'd0, crc_acc[7:0]}, fin: 1'b1});
            crc_acc = 32'hFFFFFFFF;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Stimulus driver: present the next queued word, idle at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_container(plain_q.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready)) begin
                if (feeding && plain_q.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, plain_q[0].restart, plain_q[0].nbytes,
                                      plain_q[0].blk_lo, plain_q[0].blk_hi};
                    s_axis_tlast  <= plain_q[0].last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, check each word against the oldest prediction
    always @(posedge i_clk) begin
        t_cipher want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("item_kind", m_axis_tuser, want.kind);
                    if (m_axis_tdata[63:0] !== want.hi)
                        report_mismatch("word_high", m_axis_tdata[63:0], want.hi);
                    if (m_axis_tdata[127:64] !== want.lo)
                        report_mismatch("word_low", m_axis_tdata[127:64], want.lo);
                    if (m_axis_tlast !== want.fin)
                        report_mismatch("final_item", m_axis_tlast, want.fin);
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_stall);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_word(input logic [63:0] h, input logic [63:0] l, input logic [4:0] nb,
                            input logic lst, input logic rs);
        plain_q.push_back('{blk_hi: h, blk_lo: l, nbytes: nb, last: lst, restart: rs});
    endtask

    // Write one register while the block is idle; mirror it in the model
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_HIGH: begin key_hi = val; build_round_keys(); end
            CFG_KEY_LOW:  begin key_lo = val; build_round_keys(); end
            CFG_IV_HIGH:  iv_hi = val;
            CFG_IV_LOW:   iv_lo = val;
        endcase
    endtask

    // Run the queued words, then wait until every prediction is met
    task automatic drain(input int idle, input int stall);
        send_idle = idle;
        recv_stall = stall;
        feeding = 1'b1;
        wait (plain_q.size() == 0 && !s_axis_tvalid);
        wait (cipher_q.size() == 0);
        feeding = 1'b0;
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_words(input int count);
        int nb;
        for (int i = 0; i < count; i++) begin
            nb = $urandom_range(31, 0);
            add_word(rand64(), rand64(), 5'(nb), $urandom_range(3, 0) == 0,
                     $urandom_range(7, 0) == 0);
        end
    endtask

    initial begin
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
        chain_hi = '0; chain_lo = '0;
        crc_acc = 32'hFFFFFFFF;
        #0 build_round_keys();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero key, field extremes, pad cases
        add_word('0, '0, 5'd16, 1'b0, 1'b0);
        add_word('1, '1, 5'd16, 1'b1, 1'b0);          // full last block adds a pad block
        add_word('1, '1, 5'd0, 1'b1, 1'b0);           // empty last block
        add_word('1, '1, 5'd31, 1'b1, 1'b1);          // count saturates to 16
        add_word('1, '1, 5'd3, 1'b0, 1'b0);           // short non-last uses all bytes
        add_word('1, '1, 5'd8, 1'b1, 1'b0);
        add_word('1, '1, 5'd9, 1'b1, 1'b1);
        add_word('1, '1, 5'd15, 1'b1, 1'b0);
        add_word(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd1, 1'b1, 1'b0);
        add_word(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 5'd17, 1'b1, 1'b0);
        drain(0, 0);

        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_IV_HIGH, '1);
        write_reg(CFG_IV_LOW, '1);
        add_word(rand64(), rand64(), 5'd16, 1'b0, 1'b1);
        add_word(rand64(), rand64(), 5'd7, 1'b1, 1'b0);
        add_word(rand64(), rand64(), 5'd12, 1'b1, 1'b1);
        random_words(20);
        drain(56, 0);

        write_reg(CFG_KEY_HIGH, rand64());
        write_reg(CFG_KEY_LOW, rand64());
        write_reg(CFG_IV_HIGH, rand64());
        write_reg(CFG_IV_LOW, rand64());
        random_words(25);
        drain(0, 56);

        write_reg(CFG_KEY_HIGH, 64'h2B7E151628AED2A6);
        write_reg(CFG_KEY_LOW, 64'hABF7158809CF4F3C);
        write_reg(CFG_IV_HIGH, '0);
        write_reg(CFG_IV_LOW, '0);
        random_words(26);
        drain(32, 32);

        write_reg(CFG_IV_HIGH, rand64());
        random_words(26);
        drain(0, 0);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/acce_pkg.sv
rtl/acce_round.sv
rtl/aes_cbc_container_encryptor.sv
sim/tb.sv
